FILE: design/asc_pkg.sv
// Package for the alarm snooze/silence controller: event codes, press
// request struct, timing constants and the ring-length lookup.
// No dependencies.
package asc_pkg;

   localparam int unsigned HOLD_W = 12;
   localparam int unsigned PRESS_W = 10;
   localparam int unsigned MS_W = 22;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned MIN_W = 6;
   localparam int unsigned CHOICE_W = 2;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 12;

   localparam logic [HOLD_W-1:0] HOLD_SAT = 12'd4095;
   localparam logic [MS_W-1:0] MS_PER_MINUTE = 22'd60000;
   localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd15;

   localparam logic [HOLD_W-1:0] LONG_HOLD_RESET = 12'd2000;
   localparam logic [PRESS_W-1:0] MIN_PRESS_RESET = 10'd50;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_HOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PRESS = 1'd1;

   // ring duration choices
   localparam logic [CHOICE_W-1:0] CHOICE_15_MIN = 2'd0;
   localparam logic [CHOICE_W-1:0] CHOICE_30_MIN = 2'd1;
   localparam logic [CHOICE_W-1:0] CHOICE_60_MIN = 2'd2;
   localparam logic [CHOICE_W-1:0] CHOICE_ENDLESS = 2'd3;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_STARTED  = 3'd1,
      EV_SNOOZED  = 3'd2,
      EV_LIMITED  = 3'd3,
      EV_STOPPED  = 3'd4,
      EV_RESUMED  = 3'd5,
      EV_TIMEOUT  = 3'd6
   } event_type;

   // requests raised by the button tracker for one tick
   typedef struct packed {
      logic stop_req;
      logic snooze_req;
   } press_req_type;

   // ring length in ms for a timed choice; endless reads as zero
   function automatic logic [MS_W-1:0] ring_ms(input logic [CHOICE_W-1:0] choice);
      logic [MS_W-1:0] ms;
      case (choice)
         CHOICE_15_MIN: ms = 22'd900000;
         CHOICE_30_MIN: ms = 22'd1800000;
         CHOICE_60_MIN: ms = 22'd3600000;
         default:       ms = '0;
      endcase
      return ms;
   endfunction

endpackage

FILE: design/asc_req_if.sv
// Request channel of the alarm controller: one millisecond tick per item.
// Depends on asc_pkg.
interface asc_req_if;
   logic valid;
   logic ready;
   logic button_down;
   logic start_alarm;
   logic [asc_pkg::COUNT_W-1:0] max_snoozes;
   logic [asc_pkg::MIN_W-1:0] snooze_minutes;
   logic [asc_pkg::CHOICE_W-1:0] duration_choice;

   modport source (output valid, output button_down, output start_alarm,
      output max_snoozes, output snooze_minutes, output duration_choice, input ready);
   modport sink (input valid, input button_down, input start_alarm,
      input max_snoozes, input snooze_minutes, input duration_choice, output ready);
endinterface

FILE: design/asc_rsp_if.sv
// Response channel of the alarm controller: alarm status after each tick.
// Depends on asc_pkg.
interface asc_rsp_if;
   logic valid;
   logic ready;
   logic ringing;
   logic snoozing;
   logic [asc_pkg::COUNT_W-1:0] snooze_count;
   logic [2:0] event_res;

   modport source (output valid, output ringing, output snoozing,
      output snooze_count, output event_res, input ready);
   modport sink (input valid, input ringing, input snoozing,
      input snooze_count, input event_res, output ready);
endinterface

FILE: design/alarm_snooze_silence_controller_core.sv
// Alarm snooze/silence controller top level: alarm state, config registers
// and the response register. Uses asc_pkg, asc_req_if, asc_rsp_if, asc_press.
//
//   channel   | direction | items               | handshake
//   ----------+-----------+---------------------+-------------------
//   req_chan  | in        | one ms tick         | valid/ready
//   rsp_chan  | out       | status + event code | valid/ready
//   csr_*     | in        | register write      | csr_we, no wait
//
// One item per cycle while responses are taken; its result is presented the cycle after acceptance.
// The single response register sets the rate: req_chan.ready is high while
// that register is empty or being drained in the same cycle.
// Reset is synchronous and active high; it clears all alarm state and
// reloads the register defaults (2000 ms hold, 50 ms press).
// A stalled response holds its payload and blocks new items until taken.
module alarm_snooze_silence_controller_core (
   input  logic clock,
   input  logic reset,
   asc_req_if.sink req_chan,
   asc_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [asc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [asc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic accept;
   asc_pkg::press_req_type press_req;

   logic [asc_pkg::HOLD_W-1:0] long_hold_ff;
   logic [asc_pkg::PRESS_W-1:0] min_press_ff;

   logic ring_on_ff, ring_on_in;
   logic snooze_on_ff, snooze_on_in;
   logic endless_ff, endless_in;
   logic [asc_pkg::MS_W-1:0] ring_left_ff, ring_left_in;
   logic [asc_pkg::MS_W-1:0] snooze_left_ff, snooze_left_in;
   logic [asc_pkg::COUNT_W-1:0] taken_ff, taken_in;
   logic [asc_pkg::COUNT_W-1:0] kept_limit_ff, kept_limit_in;
   logic [asc_pkg::MIN_W-1:0] kept_minutes_ff, kept_minutes_in;
   logic [asc_pkg::CHOICE_W-1:0] kept_choice_ff, kept_choice_in;
   asc_pkg::event_type ev_in;

   logic [asc_pkg::MS_W-1:0] snooze_load;
   logic [asc_pkg::MS_W-1:0] ring_dec;
   logic [asc_pkg::MS_W-1:0] snooze_dec;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ringing_ff;
   logic rsp_snoozing_ff;
   logic [asc_pkg::COUNT_W-1:0] rsp_count_ff;
   asc_pkg::event_type rsp_event_ff;

   // handshake
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         long_hold_ff <= asc_pkg::LONG_HOLD_RESET;
         min_press_ff <= asc_pkg::MIN_PRESS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            asc_pkg::CSR_LONG_HOLD: long_hold_ff <= csr_wdata[asc_pkg::HOLD_W-1:0];
            asc_pkg::CSR_MIN_PRESS: min_press_ff <= csr_wdata[asc_pkg::PRESS_W-1:0];
            default: ;
         endcase
      end
   end

   // button tracking
   asc_press u_press (
      .clock        (clock),
      .reset        (reset),
      .step_en      (accept),
      .button_down  (req_chan.button_down),
      .long_hold_ms (long_hold_ff),
      .min_press_ms (min_press_ff),
      .press_req    (press_req)
   );

   // countdown helpers
   assign snooze_load = asc_pkg::MS_W'(kept_minutes_ff * asc_pkg::MS_PER_MINUTE);
   assign ring_dec = (ring_left_ff != '0) ? ring_left_ff - 1'b1 : '0;
   assign snooze_dec = (snooze_left_ff != '0) ? snooze_left_ff - 1'b1 : '0;

   // alarm state update, priority: start, stop, snooze press, resume, timeout
   always_comb begin
      ring_on_in = ring_on_ff;
      snooze_on_in = snooze_on_ff;
      endless_in = endless_ff;
      ring_left_in = ring_left_ff;
      snooze_left_in = snooze_left_ff;
      taken_in = taken_ff;
      kept_limit_in = kept_limit_ff;
      kept_minutes_in = kept_minutes_ff;
      kept_choice_in = kept_choice_ff;
      ev_in = asc_pkg::EV_NONE;
      if (!ring_on_ff && !snooze_on_ff) begin
         if (req_chan.start_alarm) begin
            ring_on_in = 1'b1;
            taken_in = '0;
            kept_limit_in = req_chan.max_snoozes;
            kept_minutes_in = req_chan.snooze_minutes;
            kept_choice_in = req_chan.duration_choice;
            endless_in = (req_chan.duration_choice == asc_pkg::CHOICE_ENDLESS);
            ring_left_in = asc_pkg::ring_ms(req_chan.duration_choice);
            ev_in = asc_pkg::EV_STARTED;
         end
      end else if (press_req.stop_req) begin
         ring_on_in = 1'b0;
         snooze_on_in = 1'b0;
         endless_in = 1'b0;
         taken_in = '0;
         ev_in = asc_pkg::EV_STOPPED;
      end else if (ring_on_ff && press_req.snooze_req) begin
         ring_on_in = 1'b0;
         endless_in = 1'b0;
         if (kept_limit_ff != '0 && taken_ff >= kept_limit_ff) begin
            ev_in = asc_pkg::EV_LIMITED;
         end else begin
            if (taken_ff < asc_pkg::COUNT_SAT) begin
               taken_in = taken_ff + 1'b1;
            end
            snooze_on_in = 1'b1;
            snooze_left_in = snooze_load;
            ev_in = asc_pkg::EV_SNOOZED;
         end
      end else if (snooze_on_ff) begin
         snooze_left_in = snooze_dec;
         if (snooze_dec == '0) begin
            snooze_on_in = 1'b0;
            ring_on_in = 1'b1;
            endless_in = (kept_choice_ff == asc_pkg::CHOICE_ENDLESS);
            ring_left_in = asc_pkg::ring_ms(kept_choice_ff);
            ev_in = asc_pkg::EV_RESUMED;
         end
      end else if (ring_on_ff && !endless_ff) begin
         ring_left_in = ring_dec;
         if (ring_dec == '0) begin
            ring_on_in = 1'b0;
            ev_in = asc_pkg::EV_TIMEOUT;
         end
      end
   end

   // alarm control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_on_ff <= 1'b0;
         snooze_on_ff <= 1'b0;
         endless_ff <= 1'b0;
         ring_left_ff <= '0;
         snooze_left_ff <= '0;
         taken_ff <= '0;
         kept_limit_ff <= '0;
         kept_minutes_ff <= '0;
         kept_choice_ff <= '0;
      end else if (accept) begin
         ring_on_ff <= ring_on_in;
         snooze_on_ff <= snooze_on_in;
         endless_ff <= endless_in;
         ring_left_ff <= ring_left_in;
         snooze_left_ff <= snooze_left_in;
         taken_ff <= taken_in;
         kept_limit_ff <= kept_limit_in;
         kept_minutes_ff <= kept_minutes_in;
         kept_choice_ff <= kept_choice_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ringing_ff <= ring_on_in;
         rsp_snoozing_ff <= snooze_on_in;
         rsp_count_ff <= taken_in;
         rsp_event_ff <= ev_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.ringing = rsp_ringing_ff;
   assign rsp_chan.snoozing = rsp_snoozing_ff;
   assign rsp_chan.snooze_count = rsp_count_ff;
   assign rsp_chan.event_res = rsp_event_ff;

   // checks
   a_ring_snooze_excl: assert property (@(posedge clock) disable iff (reset)
      !(ring_on_ff && snooze_on_ff))
      else $error("ringing and snoozing at once");

   a_endless_rings: assert property (@(posedge clock) disable iff (reset)
      endless_ff |-> ring_on_ff)
      else $error("endless flag set without ringing");

   // a zero-minute snooze loads zero and resumes on the next item
   a_snooze_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && ev_in == asc_pkg::EV_SNOOZED) |=> snooze_on_ff)
      else $error("snooze event did not start a snooze");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(taken_ff))
      else $error("snooze count moved without an item");

endmodule

FILE: design/asc_press.sv
// Snooze button tracker: measures press length per tick and raises
// stop (long hold) and snooze (short press release) requests. Uses asc_pkg.
module asc_press (
   input  logic clock,
   input  logic reset,
   input  logic step_en,
   input  logic button_down,
   input  logic [asc_pkg::HOLD_W-1:0] long_hold_ms,
   input  logic [asc_pkg::PRESS_W-1:0] min_press_ms,
   output asc_pkg::press_req_type press_req
);

   logic last_button_ff, last_button_in;
   logic hold_done_ff, hold_done_in;
   logic [asc_pkg::HOLD_W-1:0] hold_ms_ff, hold_ms_in;
   logic [asc_pkg::HOLD_W-1:0] hold_inc;
   logic [asc_pkg::HOLD_W-1:0] release_ms;

   // saturating press counter
   assign hold_inc = (hold_ms_ff < asc_pkg::HOLD_SAT) ? hold_ms_ff + 1'b1 : asc_pkg::HOLD_SAT;
   assign release_ms = hold_inc;

   // edge decode and request generation
   always_comb begin
      last_button_in = button_down;
      hold_ms_in = hold_ms_ff;
      hold_done_in = hold_done_ff;
      press_req = '0;
      if (button_down && !last_button_ff) begin
         hold_ms_in = '0;
         hold_done_in = 1'b0;
      end else if (button_down && last_button_ff) begin
         hold_ms_in = hold_inc;
         if (!hold_done_ff && hold_inc >= long_hold_ms) begin
            press_req.stop_req = 1'b1;
            hold_done_in = 1'b1;
         end
      end else if (!button_down && last_button_ff) begin
         if (!hold_done_ff && release_ms >= {2'b00, min_press_ms}) begin
            press_req.snooze_req = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_button_ff <= 1'b0;
         hold_ms_ff <= '0;
         hold_done_ff <= 1'b0;
      end else if (step_en) begin
         last_button_ff <= last_button_in;
         hold_ms_ff <= hold_ms_in;
         hold_done_ff <= hold_done_in;
      end
   end

endmodule

FILE: sim/alarm_status_checker.sv
// Scoreboard for the alarm snooze/silence controller: snoops the tick and
// status channels and the csr port, predicts each status item and compares.
// Depends on asc_pkg.
module alarm_status_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic req_button_down,
   input  logic req_start_alarm,
   input  logic [asc_pkg::COUNT_W-1:0] req_max_snoozes,
   input  logic [asc_pkg::MIN_W-1:0] req_snooze_minutes,
   input  logic [asc_pkg::CHOICE_W-1:0] req_duration_choice,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic rsp_ringing,
   input  logic rsp_snoozing,
   input  logic [asc_pkg::COUNT_W-1:0] rsp_snooze_count,
   input  logic [2:0] rsp_event_res,
   input  logic csr_we,
   input  logic [asc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [asc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned pending_count,
   output int unsigned fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [asc_pkg::MS_W-1:0] RING_15_MS = 22'd900000;
   localparam logic [asc_pkg::MS_W-1:0] RING_30_MS = 22'd1800000;
   localparam logic [asc_pkg::MS_W-1:0] RING_60_MS = 22'd3600000;

   typedef struct packed {
      logic ringing;
      logic snoozing;
      logic [asc_pkg::COUNT_W-1:0] count;
      asc_pkg::event_type ev;
   } alarm_status_type;

   // status items owed by the block, oldest first
   alarm_status_type expected_status[$];
   alarm_status_type fresh_status;
   alarm_status_type due;
   int unsigned mismatches = 0;

   // shadow registers
   logic [asc_pkg::HOLD_W-1:0] stop_hold_ms;
   logic [asc_pkg::PRESS_W-1:0] press_min_ms;

   // shadow alarm state
   logic last_btn;
   logic [asc_pkg::HOLD_W-1:0] held_ms;
   logic hold_fired;
   logic ringing_now;
   logic snoozing_now;
   logic ring_forever;
   logic [asc_pkg::MS_W-1:0] ring_left_ms;
   logic [asc_pkg::MS_W-1:0] snooze_left_ms;
   logic [asc_pkg::COUNT_W-1:0] snoozes_taken;
   logic [asc_pkg::COUNT_W-1:0] snooze_limit;
   logic [asc_pkg::MIN_W-1:0] snooze_len_min;
   logic [asc_pkg::CHOICE_W-1:0] ring_choice;

   // load the ring timer for a duration choice; endless never counts down
   task load_ring(input logic [asc_pkg::CHOICE_W-1:0] choice);
      case (choice)
         asc_pkg::CHOICE_15_MIN: begin
            ring_forever = 1'b0;
            ring_left_ms = RING_15_MS;
         end
         asc_pkg::CHOICE_30_MIN: begin
            ring_forever = 1'b0;
            ring_left_ms = RING_30_MS;
         end
         asc_pkg::CHOICE_60_MIN: begin
            ring_forever = 1'b0;
            ring_left_ms = RING_60_MS;
         end
         default: begin
            ring_forever = 1'b1;
            ring_left_ms = '0;
         end
      endcase
   endtask

   // advance the shadow alarm by one millisecond tick
   task advance_alarm(input logic btn, input logic start,
         input logic [asc_pkg::COUNT_W-1:0] lim,
         input logic [asc_pkg::MIN_W-1:0] mins,
         input logic [asc_pkg::CHOICE_W-1:0] choice,
         output alarm_status_type st);
      logic stop_now;
      logic snooze_now;
      logic [asc_pkg::HOLD_W:0] press_len;
      asc_pkg::event_type ev;
      stop_now = 1'b0;
      snooze_now = 1'b0;
      ev = asc_pkg::EV_NONE;

      // button press tracking
      if (btn && !last_btn) begin
         held_ms = '0;
         hold_fired = 1'b0;
      end else if (btn && last_btn) begin
         if (held_ms != asc_pkg::HOLD_SAT)
            held_ms = held_ms + 1'b1;
         if (!hold_fired && held_ms >= stop_hold_ms) begin
            stop_now = 1'b1;
            hold_fired = 1'b1;
         end
      end else if (!btn && last_btn) begin
         press_len = (held_ms != asc_pkg::HOLD_SAT) ? {1'b0, held_ms} + 1'b1
                                                    : {1'b0, asc_pkg::HOLD_SAT};
         if (!hold_fired && press_len >= press_min_ms)
            snooze_now = 1'b1;
      end
      last_btn = btn;

      // alarm state, judged on the state at the start of the tick
      if (!ringing_now && !snoozing_now) begin
         if (start) begin
            ringing_now = 1'b1;
            snoozes_taken = '0;
            snooze_limit = lim;
            snooze_len_min = mins;
            ring_choice = choice;
            load_ring(choice);
            ev = asc_pkg::EV_STARTED;
         end
      end else if (stop_now) begin
         ringing_now = 1'b0;
         snoozing_now = 1'b0;
         ring_forever = 1'b0;
         snoozes_taken = '0;
         ev = asc_pkg::EV_STOPPED;
      end else if (ringing_now && snooze_now) begin
         if (snooze_limit != 0 && snoozes_taken >= snooze_limit) begin
            ringing_now = 1'b0;
            ring_forever = 1'b0;
            ev = asc_pkg::EV_LIMITED;
         end else begin
            if (snoozes_taken != asc_pkg::COUNT_SAT)
               snoozes_taken = snoozes_taken + 1'b1;
            ringing_now = 1'b0;
            ring_forever = 1'b0;
            snoozing_now = 1'b1;
            snooze_left_ms = snooze_len_min * asc_pkg::MS_PER_MINUTE;
            ev = asc_pkg::EV_SNOOZED;
         end
      end else if (snoozing_now) begin
         if (snooze_left_ms != 0)
            snooze_left_ms = snooze_left_ms - 1'b1;
         if (snooze_left_ms == 0) begin
            snoozing_now = 1'b0;
            ringing_now = 1'b1;
            load_ring(ring_choice);
            ev = asc_pkg::EV_RESUMED;
         end
      end else if (ringing_now && !ring_forever) begin
         if (ring_left_ms != 0)
            ring_left_ms = ring_left_ms - 1'b1;
         if (ring_left_ms == 0) begin
            ringing_now = 1'b0;
            ev = asc_pkg::EV_TIMEOUT;
         end
      end

      st.ringing = ringing_now;
      st.snoozing = snoozing_now;
      st.count = snoozes_taken;
      st.ev = ev;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         stop_hold_ms = asc_pkg::LONG_HOLD_RESET;
         press_min_ms = asc_pkg::MIN_PRESS_RESET;
         last_btn = 1'b0;
         held_ms = '0;
         hold_fired = 1'b0;
         ringing_now = 1'b0;
         snoozing_now = 1'b0;
         ring_forever = 1'b0;
         ring_left_ms = '0;
         snooze_left_ms = '0;
         snoozes_taken = '0;
         snooze_limit = '0;
         snooze_len_min = '0;
         ring_choice = '0;
         expected_status.delete();
      end else begin
         // register writes
         if (csr_we) begin
            if (csr_index == asc_pkg::CSR_LONG_HOLD)
               stop_hold_ms = csr_wdata[asc_pkg::HOLD_W-1:0];
            else if (csr_index == asc_pkg::CSR_MIN_PRESS)
               press_min_ms = csr_wdata[asc_pkg::PRESS_W-1:0];
         end

         // compare a delivered status item with the oldest one owed
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               $error("status item with no tick owed: ringing=%0b snoozing=%0b count=%0d ev=%0d",
                  rsp_ringing, rsp_snoozing, rsp_snooze_count, rsp_event_res);
               mismatches++;
            end else begin
               due = expected_status.pop_front();
               if (rsp_ringing !== due.ringing) begin
                  $error("ringing: expected %0b, got %0b", due.ringing, rsp_ringing);
                  mismatches++;
               end
               if (rsp_snoozing !== due.snoozing) begin
                  $error("snoozing: expected %0b, got %0b", due.snoozing, rsp_snoozing);
                  mismatches++;
               end
               if (rsp_snooze_count !== due.count) begin
                  $error("snooze_count: expected %0d, got %0d", due.count, rsp_snooze_count);
                  mismatches++;
               end
               if (rsp_event_res !== due.ev) begin
                  $error("event_res: expected %0d, got %0d", due.ev, rsp_event_res);
                  mismatches++;
               end
            end
         end

         // predict the status for an accepted tick
         if (req_valid && req_ready) begin
            advance_alarm(req_button_down, req_start_alarm, req_max_snoozes,
               req_snooze_minutes, req_duration_choice, fresh_status);
            expected_status.push_back(fresh_status);
         end
      end
      pending_count <= expected_status.size();
      fail_count <= mismatches;
   end

endmodule

FILE: sim/tb_alarm_snooze_silence_controller_core.sv
// Testbench top for the alarm snooze/silence controller: clock, reset, tick
// stimulus, csr writes and the verdict. Checking lives in alarm_status_checker.
// Depends on asc_pkg, asc_req_if, asc_rsp_if and the controller core.
module tb_alarm_snooze_silence_controller_core;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [asc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [asc_pkg::CSR_DATA_W-1:0] csr_wdata;
   int unsigned pending_count;
   int unsigned fail_count;

   // idling knobs, in percent
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;

   // long status hold-off, asked by the stimulus and counted by the receiver
   int unsigned hold_off_asked = 0;
   int unsigned hold_off_served = 0;
   int unsigned hold_off_left = 0;

   int unsigned ticks_sent = 0;
   logic [asc_pkg::HOLD_W-1:0] cur_hold = asc_pkg::LONG_HOLD_RESET;
   logic [asc_pkg::PRESS_W-1:0] cur_press = asc_pkg::MIN_PRESS_RESET;

   asc_req_if req_if ();
   asc_rsp_if rsp_if ();

   alarm_snooze_silence_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   alarm_status_checker status_chk (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_if.valid),
      .req_ready           (req_if.ready),
      .req_button_down     (req_if.button_down),
      .req_start_alarm     (req_if.start_alarm),
      .req_max_snoozes     (req_if.max_snoozes),
      .req_snooze_minutes  (req_if.snooze_minutes),
      .req_duration_choice (req_if.duration_choice),
      .rsp_valid           (rsp_if.valid),
      .rsp_ready           (rsp_if.ready),
      .rsp_ringing         (rsp_if.ringing),
      .rsp_snoozing        (rsp_if.snoozing),
      .rsp_snooze_count    (rsp_if.snooze_count),
      .rsp_event_res       (rsp_if.event_res),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .pending_count       (pending_count),
      .fail_count          (fail_count)
   );

   always #2 clock = ~clock;

   // status receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_off_asked != hold_off_served) begin
         hold_off_served = hold_off_asked;
         hold_off_left = 80;
      end
      if (hold_off_left != 0) begin
         hold_off_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // offer one tick and wait for it to be taken, then maybe go idle
   task automatic send_tick(input logic btn, input logic start,
         input logic [asc_pkg::COUNT_W-1:0] lim, input logic [asc_pkg::MIN_W-1:0] mins,
         input logic [asc_pkg::CHOICE_W-1:0] choice);
      req_if.valid <= 1'b1;
      req_if.button_down <= btn;
      req_if.start_alarm <= start;
      req_if.max_snoozes <= lim;
      req_if.snooze_minutes <= mins;
      req_if.duration_choice <= choice;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      ticks_sent++;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // tick with random alarm settings riding along
   task automatic tick(input logic btn, input logic start);
      send_tick(btn, start, 4'($urandom_range(15)), 6'($urandom_range(63)),
         2'($urandom_range(3)));
   endtask

   // button held for n ticks, then released
   task automatic press_for(input int unsigned n);
      repeat (n) tick(1'b1, 1'b0);
      tick(1'b0, 1'b0);
   endtask

   // stop offering and wait until every owed status item is in
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // write both registers while the block is quiet
   task automatic write_regs(input logic [asc_pkg::HOLD_W-1:0] hold,
         input logic [asc_pkg::PRESS_W-1:0] press);
      drain();
      csr_we <= 1'b1;
      csr_index <= asc_pkg::CSR_LONG_HOLD;
      csr_wdata <= hold;
      @(posedge clock);
      csr_index <= asc_pkg::CSR_MIN_PRESS;
      csr_wdata <= {2'b00, press};
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      cur_hold = hold;
      cur_press = press;
   endtask

   // one alarm: start, a burst of presses around the thresholds, some noise
   task automatic run_episode();
      int unsigned presses;
      int unsigned len;
      logic [asc_pkg::COUNT_W-1:0] lim;
      logic [asc_pkg::MIN_W-1:0] mins;
      lim = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
      mins = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'd0;
      send_tick(1'b0, 1'b1, lim, mins, 2'($urandom_range(3)));
      presses = $urandom_range(1, 8);
      repeat (presses) begin
         repeat ($urandom_range(3)) tick(1'b0, $urandom_range(9) == 0);
         case ($urandom_range(3))
            0: len = $urandom_range(1, cur_press + 1);
            1: len = cur_press + $urandom_range(2);
            2: len = cur_hold + 1;
            default: len = $urandom_range(1, cur_hold + 3);
         endcase
         if (len == 0)
            len = 1;
         press_for(len);
      end
      if ($urandom_range(4) == 0)
         repeat (8) tick(1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   initial begin
      int unsigned phase_base;
      logic [asc_pkg::HOLD_W-1:0] hold_pick;
      logic [asc_pkg::PRESS_W-1:0] press_pick;
      req_if.valid = 1'b0;
      req_if.button_down = 1'b0;
      req_if.start_alarm = 1'b0;
      req_if.max_snoozes = '0;
      req_if.snooze_minutes = '0;
      req_if.duration_choice = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: endless ring, short press just under and at 50 ms,
      // zero-length snooze resumes next tick
      tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1, 4'd0, 6'd0, asc_pkg::CHOICE_ENDLESS);
      press_for(49);
      press_for(50);
      tick(1'b0, 1'b0);

      // short hold stops the endless ring; presses while idle do nothing
      write_regs(12'd6, 10'd3);
      press_for(8);
      press_for(10);

      // zero hold and zero press registers
      write_regs(12'd0, 10'd0);
      send_tick(1'b0, 1'b1, 4'd1, 6'd0, asc_pkg::CHOICE_15_MIN);
      press_for(1);
      tick(1'b0, 1'b0);
      press_for(1);
      // start on a tick with the button going down, then stop on the next
      send_tick(1'b1, 1'b1, 4'd3, 6'd5, asc_pkg::CHOICE_30_MIN);
      press_for(1);

      // top of both registers, start while busy, then the longest snooze
      write_regs(12'd4095, 10'd1023);
      send_tick(1'b0, 1'b1, 4'd2, 6'd63, asc_pkg::CHOICE_60_MIN);
      press_for(3);
      send_tick(1'b0, 1'b1, 4'd0, 6'd0, asc_pkg::CHOICE_ENDLESS);
      write_regs(12'd3, 10'd2);
      press_for(2);
      press_for(4);

      // snooze limit reached, then an unlimited alarm saturating the count
      send_tick(1'b0, 1'b1, 4'd3, 6'd0, asc_pkg::CHOICE_30_MIN);
      repeat (4) begin
         press_for(2);
         tick(1'b0, 1'b0);
      end
      send_tick(1'b0, 1'b1, 4'd0, 6'd0, asc_pkg::CHOICE_ENDLESS);
      repeat (17) begin
         press_for(2);
         tick(1'b0, 1'b0);
      end
      press_for(4);

      // random alarms across register settings and idling modes
      for (int p = 0; p < 8; p++) begin
         press_pick = ($urandom_range(3) == 0) ? 10'd0 : 10'($urandom_range(1, 10));
         hold_pick = ($urandom_range(4) == 0) ? 12'($urandom_range(1))
                                              : 12'(press_pick + $urandom_range(1, 12));
         write_regs(hold_pick, press_pick);
         case (p % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 61; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 61; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         // receiver holds off while ticks keep coming
         if (p == 4)
            hold_off_asked++;
         phase_base = ticks_sent;
         while (ticks_sent - phase_base < 30)
            run_episode();
      end

      drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #400_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
design/asc_pkg.sv
design/asc_req_if.sv
design/asc_rsp_if.sv
design/asc_press.sv
design/alarm_snooze_silence_controller_core.sv
sim/alarm_status_checker.sv
sim/tb_alarm_snooze_silence_controller_core.sv
